@@ hdl/mfl_pkg.sv @@
// Shared types, codes and constants for the max-flow level-graph engine.
// No dependencies; mfl_dp, mfl_ctrl and the top level in hdl/ import this package.
package mfl_pkg;

   // default sizes, handed to the top level as parameter defaults
   localparam int NODES_DEF    = 64;
   localparam int MAX_ARCS_DEF = 8192;

   // fixed field widths
   localparam int NODE_W  = 6;
   localparam int CAP_W   = 30;
   localparam int RES_W   = 31;
   localparam int FLOW_W  = 36;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 40;
   localparam int CSR_IDX_W = 1;

   // push limit of one augmentation phase
   localparam logic [CAP_W-1:0] PUSH_LIMIT = 30'd1000000000;

   // request actions
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_SOLVE = 2'd2
   } mfl_act_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE = 1'd0,
      CSR_SINK   = 1'd1
   } mfl_csr_type;

   // controller states
   typedef enum logic [5:0] {
      S_RST, S_IDLE, S_DISPATCH, S_CLR,
      S_ADD_RD1, S_ADD_WR1, S_ADD_RD2, S_ADD_WR2,
      S_LVL_CLR, S_BFS_SEED, S_BFS_POP, S_BFS_U, S_BFS_U2,
      S_BFS_ARC, S_BFS_LAT, S_BFS_CHK, S_SNK_CHK,
      S_CP_RD, S_CP_WR, S_AUG_START, S_AUG_TOP, S_CUR_LAT,
      S_SCAN, S_SCAN_LAT, S_SCAN_CHK, S_DEAD, S_BACK, S_BACK_U,
      S_MIN_RD, S_MIN_S, S_MIN_C, S_UPD_RD, S_UPD_S, S_UPD_A, S_UPD_B,
      S_PHASE_END, S_DONE
   } mfl_state_type;

   // datapath micro-operations
   typedef enum logic [5:0] {
      OP_NONE, OP_ACCEPT, OP_CLR, OP_ADD_ERR,
      OP_ADD_RD1, OP_ADD_WR1, OP_ADD_RD2, OP_ADD_WR2,
      OP_LVL_CLR, OP_BFS_SEED, OP_BFS_POP, OP_BFS_U, OP_BFS_U2,
      OP_ARC_RD, OP_ARC_LAT, OP_BFS_TAKE, OP_NEXT_ARC, OP_SNK_RD,
      OP_CP_RD, OP_CP_WR, OP_AUG_START, OP_CUR_RD, OP_CUR_LAT,
      OP_CUR_NIL, OP_ADVANCE, OP_PRUNE, OP_BACK, OP_BACK_U,
      OP_PATH, OP_STK_RD, OP_RES_RD, OP_MIN, OP_UPD_START,
      OP_UPD_A, OP_UPD_B, OP_PUSH, OP_PHASE_END, OP_RESP
   } mfl_op_type;

   typedef struct packed {
      mfl_op_type op;
   } mfl_cmd_type;

   typedef struct packed {
      mfl_act_type act;
      logic add_ok;
      logic solve_ok;
      logic sweep_last;
      logic q_nonempty;
      logic e_nil;
      logic bfs_take;
      logic snk_reached;
      logic push_done;
      logic at_sink;
      logic arc_ok;
      logic depth_full;
      logic depth_zero;
      logic i_lt_depth;
      logic out_free;
   } mfl_status_type;

endpackage

@@ hdl/mfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/mfl_dp.sv @@
// Datapath of the max-flow engine: graph tables, search scratch memories,
// working registers and the result register. Depends on mfl_pkg, mfl_ram.
module mfl_dp #(
   parameter int NODES    = mfl_pkg::NODES_DEF,
   parameter int MAX_ARCS = mfl_pkg::MAX_ARCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mfl_pkg::mfl_cmd_type          cmd,
   output mfl_pkg::mfl_status_type       status,
   input  logic [mfl_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          csr_valid,
   input  logic [mfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfl_pkg::NODE_W-1:0]    csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mfl_pkg::RSP_W-1:0]     rsp_tdata
);
   import mfl_pkg::*;

   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(MAX_ARCS);
   localparam int EW = AW + 1;
   localparam int LW = NW + 1;
   localparam logic [EW-1:0] NIL_ARC  = EW'(MAX_ARCS);
   localparam logic [LW-1:0] NO_LEVEL = '1;
   localparam logic [NW:0]   NODES_C  = (NW+1)'(NODES);

   // configuration and request registers
   logic [NODE_W-1:0] src_ff, snk_ff;
   mfl_act_type       act_ff, act_in;
   logic [NODE_W-1:0] from_ff, from_in, to_ff, to_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;

   // working registers
   logic [EW-1:0]     arc_cnt_ff, arc_cnt_in;
   logic [NW-1:0]     v_ff, v_in, v_next;
   logic [NW-1:0]     u_ff, u_in, w_ff, w_in;
   logic [EW-1:0]     e_ff, e_in, nxt_ff, nxt_in;
   logic [RES_W-1:0]  r_ff, r_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [NW:0]       qh_ff, qh_in, qt_ff, qt_in;
   logic [NW:0]       depth_ff, depth_in, i_ff, i_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [CAP_W-1:0]  pushed_ff, pushed_in, b_ff, b_in;
   logic [FLOW_W-1:0] total_ff, total_in;
   logic              st_ff, st_in;
   logic [FLOW_W:0]   total_sum;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_st_ff, rsp_st_in;
   logic [FLOW_W-1:0] rsp_flow_ff, rsp_flow_in;

   // memory ports
   logic              head_we, res_we, next_we, first_we, cur_we, lvl_we, q_we, stk_we;
   logic [AW-1:0]     head_wa, head_ra, res_wa, res_ra, next_wa, next_ra;
   logic [NW-1:0]     first_wa, first_ra, cur_wa, cur_ra, lvl_wa, lvl_ra;
   logic [NW-1:0]     q_wa, q_ra, stk_wa, stk_ra;
   logic [NW-1:0]     head_wd, head_rd, q_wd, q_rd;
   logic [RES_W-1:0]  res_wd, res_rd;
   logic [EW-1:0]     next_wd, next_rd, first_wd, first_rd, cur_wd, cur_rd;
   logic [LW-1:0]     lvl_wd, lvl_rd;
   logic [AW-1:0]     stk_wd, stk_rd;

   mfl_ram #(.WIDTH(NW),    .DEPTH(MAX_ARCS)) u_head (.clock(clock), .we(head_we),
      .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
   mfl_ram #(.WIDTH(RES_W), .DEPTH(MAX_ARCS)) u_res (.clock(clock), .we(res_we),
      .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd));
   mfl_ram #(.WIDTH(EW),    .DEPTH(MAX_ARCS)) u_next (.clock(clock), .we(next_we),
      .waddr(next_wa), .wdata(next_wd), .raddr(next_ra), .rdata(next_rd));
   mfl_ram #(.WIDTH(EW),    .DEPTH(NODES)) u_first (.clock(clock), .we(first_we),
      .waddr(first_wa), .wdata(first_wd), .raddr(first_ra), .rdata(first_rd));
   mfl_ram #(.WIDTH(EW),    .DEPTH(NODES)) u_cur (.clock(clock), .we(cur_we),
      .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
   mfl_ram #(.WIDTH(LW),    .DEPTH(NODES)) u_level (.clock(clock), .we(lvl_we),
      .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd));
   mfl_ram #(.WIDTH(NW),    .DEPTH(NODES)) u_queue (.clock(clock), .we(q_we),
      .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
   mfl_ram #(.WIDTH(AW),    .DEPTH(NODES)) u_stack (.clock(clock), .we(stk_we),
      .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

   // sweep counter wraps at the node count
   assign v_next = (v_ff == NW'(NODES - 1)) ? '0 : v_ff + NW'(1);
   assign total_sum = {1'b0, total_ff} + (FLOW_W+1)'(pushed_ff);

   // micro-operation decode
   always_comb begin
      act_in = act_ff;  from_in = from_ff;  to_in = to_ff;  cap_in = cap_ff;
      arc_cnt_in = arc_cnt_ff;  v_in = v_ff;  u_in = u_ff;  w_in = w_ff;
      e_in = e_ff;  nxt_in = nxt_ff;  r_in = r_ff;  lvl_in = lvl_ff;
      qh_in = qh_ff;  qt_in = qt_ff;  depth_in = depth_ff;  i_in = i_ff;
      p_in = p_ff;  pushed_in = pushed_ff;  b_in = b_ff;  total_in = total_ff;
      st_in = st_ff;  rsp_st_in = rsp_st_ff;  rsp_flow_in = rsp_flow_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      head_we = 1'b0;  head_wa = AW'(arc_cnt_ff);  head_wd = NW'(to_ff);
      head_ra = AW'(e_ff);
      res_we = 1'b0;   res_wa = AW'(arc_cnt_ff);   res_wd = RES_W'(cap_ff);
      res_ra = AW'(e_ff);
      next_we = 1'b0;  next_wa = AW'(arc_cnt_ff);  next_wd = first_rd;
      next_ra = AW'(e_ff);
      first_we = 1'b0; first_wa = v_ff;  first_wd = NIL_ARC;  first_ra = v_ff;
      cur_we = 1'b0;   cur_wa = v_ff;    cur_wd = first_rd;   cur_ra = u_ff;
      lvl_we = 1'b0;   lvl_wa = v_ff;    lvl_wd = NO_LEVEL;   lvl_ra = u_ff;
      q_we = 1'b0;     q_wa = qt_ff[NW-1:0];  q_wd = w_ff;    q_ra = qh_ff[NW-1:0];
      stk_we = 1'b0;   stk_wa = depth_ff[NW-1:0]; stk_wd = AW'(e_ff);
      stk_ra = i_ff[NW-1:0];

      unique case (cmd.op)
         OP_ACCEPT: begin
            act_in  = mfl_act_type'(req_tdata[1:0]);
            from_in = req_tdata[7:2];
            to_in   = req_tdata[13:8];
            cap_in  = req_tdata[43:14];
            st_in   = 1'b0;
            total_in = '0;
         end
         OP_CLR: begin
            first_we = 1'b1;
            v_in = v_next;
            arc_cnt_in = '0;
         end
         OP_ADD_ERR: st_in = 1'b1;
         OP_ADD_RD1: first_ra = NW'(from_ff);
         OP_ADD_WR1: begin
            // forward arc, prepended to the tail node's list
            head_we = 1'b1;  res_we = 1'b1;  next_we = 1'b1;
            first_we = 1'b1; first_wa = NW'(from_ff); first_wd = arc_cnt_ff;
         end
         OP_ADD_RD2: first_ra = NW'(to_ff);
         OP_ADD_WR2: begin
            // paired reverse arc with no capacity
            head_we = 1'b1;  head_wa = AW'(arc_cnt_ff + EW'(1));  head_wd = NW'(from_ff);
            res_we = 1'b1;   res_wa = AW'(arc_cnt_ff + EW'(1));   res_wd = '0;
            next_we = 1'b1;  next_wa = AW'(arc_cnt_ff + EW'(1));
            first_we = 1'b1; first_wa = NW'(to_ff); first_wd = arc_cnt_ff + EW'(1);
            arc_cnt_in = arc_cnt_ff + EW'(2);
         end
         OP_LVL_CLR: begin
            lvl_we = 1'b1;
            v_in = v_next;
         end
         OP_BFS_SEED: begin
            lvl_we = 1'b1;  lvl_wa = NW'(src_ff);  lvl_wd = '0;
            q_we = 1'b1;    q_wa = '0;             q_wd = NW'(src_ff);
            qh_in = '0;
            qt_in = (NW+1)'(1);
         end
         OP_BFS_POP: qh_in = qh_ff + (NW+1)'(1);
         OP_BFS_U: begin
            u_in = q_rd;
            first_ra = q_rd;
            lvl_ra = q_rd;
         end
         OP_BFS_U2: begin
            e_in = first_rd;
            lvl_in = lvl_rd;
         end
         OP_ARC_RD: ;
         OP_ARC_LAT: begin
            w_in = head_rd;
            r_in = res_rd;
            nxt_in = next_rd;
            lvl_ra = head_rd;
         end
         OP_BFS_TAKE: begin
            lvl_we = 1'b1;  lvl_wa = w_ff;  lvl_wd = lvl_ff + LW'(1);
            q_we = 1'b1;
            qt_in = qt_ff + (NW+1)'(1);
            e_in = nxt_ff;
         end
         OP_NEXT_ARC: e_in = nxt_ff;
         OP_SNK_RD: lvl_ra = NW'(snk_ff);
         OP_CP_RD: ;
         OP_CP_WR: begin
            cur_we = 1'b1;
            v_in = v_next;
         end
         OP_AUG_START: begin
            pushed_in = '0;
            depth_in = '0;
            u_in = NW'(src_ff);
         end
         OP_CUR_RD: ;
         OP_CUR_LAT: begin
            e_in = cur_rd;
            lvl_in = lvl_rd;
         end
         OP_CUR_NIL: begin
            cur_we = 1'b1;  cur_wa = u_ff;  cur_wd = e_ff;
         end
         OP_ADVANCE: begin
            cur_we = 1'b1;  cur_wa = u_ff;  cur_wd = e_ff;
            stk_we = 1'b1;
            depth_in = depth_ff + (NW+1)'(1);
            u_in = w_ff;
         end
         OP_PRUNE: begin
            // dead end: drop the node for the rest of the phase
            lvl_we = 1'b1;  lvl_wa = u_ff;
            depth_in = depth_ff - (NW+1)'(1);
            stk_ra = NW'(depth_ff - (NW+1)'(1));
         end
         OP_BACK: begin
            p_in = stk_rd;
            head_ra = stk_rd ^ AW'(1);
         end
         OP_BACK_U: u_in = head_rd;
         OP_PATH: begin
            b_in = PUSH_LIMIT - pushed_ff;
            i_in = '0;
         end
         OP_STK_RD: ;
         OP_RES_RD: begin
            p_in = stk_rd;
            res_ra = stk_rd;
         end
         OP_MIN: begin
            if (res_rd < RES_W'(b_ff)) begin
               b_in = CAP_W'(res_rd);
            end
            i_in = i_ff + (NW+1)'(1);
         end
         OP_UPD_START: i_in = '0;
         OP_UPD_A: begin
            res_we = 1'b1;  res_wa = p_ff;  res_wd = res_rd - RES_W'(b_ff);
            res_ra = p_ff ^ AW'(1);
         end
         OP_UPD_B: begin
            res_we = 1'b1;  res_wa = p_ff ^ AW'(1);  res_wd = res_rd + RES_W'(b_ff);
            i_in = i_ff + (NW+1)'(1);
         end
         OP_PUSH: begin
            pushed_in = pushed_ff + b_ff;
            depth_in = '0;
            u_in = NW'(src_ff);
         end
         OP_PHASE_END: total_in = total_sum[FLOW_W] ? '1 : total_sum[FLOW_W-1:0];
         OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_st_in = st_ff;
            rsp_flow_in = total_ff;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= '0;
         snk_ff <= NODE_W'(1);
         v_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_SOURCE) begin
            src_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_SINK) begin
            snk_ff <= csr_data;
         end
         v_ff <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;  from_ff <= from_in;  to_ff <= to_in;  cap_ff <= cap_in;
      arc_cnt_ff <= arc_cnt_in;  u_ff <= u_in;  w_ff <= w_in;  e_ff <= e_in;
      nxt_ff <= nxt_in;  r_ff <= r_in;  lvl_ff <= lvl_in;  qh_ff <= qh_in;
      qt_ff <= qt_in;  depth_ff <= depth_in;  i_ff <= i_in;  p_ff <= p_in;
      pushed_ff <= pushed_in;  b_ff <= b_in;  total_ff <= total_in;  st_ff <= st_in;
      rsp_st_ff <= rsp_st_in;  rsp_flow_ff <= rsp_flow_in;
   end

   // status towards the controller
   always_comb begin
      status.act         = act_ff;
      status.add_ok      = (32'(from_ff) < 32'(NODES)) && (32'(to_ff) < 32'(NODES)) &&
                           ((EW+1)'(arc_cnt_ff) + (EW+1)'(2) <= (EW+1)'(MAX_ARCS));
      status.solve_ok    = (32'(src_ff) < 32'(NODES)) && (32'(snk_ff) < 32'(NODES)) &&
                           (src_ff != snk_ff);
      status.sweep_last  = (v_ff == NW'(NODES - 1));
      status.q_nonempty  = (qh_ff < qt_ff);
      status.e_nil       = (e_ff >= NIL_ARC);
      status.bfs_take    = (lvl_rd == NO_LEVEL) && (r_ff != '0) && (qt_ff < NODES_C);
      status.snk_reached = (lvl_rd != NO_LEVEL);
      status.push_done   = (pushed_ff >= PUSH_LIMIT);
      status.at_sink     = (u_ff == NW'(snk_ff));
      status.arc_ok      = (r_ff != '0) && (lvl_rd == lvl_ff + LW'(1));
      status.depth_full  = (depth_ff >= NODES_C);
      status.depth_zero  = (depth_ff == '0);
      status.i_lt_depth  = (i_ff < depth_ff);
      status.out_free    = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_flow_ff, rsp_st_ff};

endmodule

@@ hdl/mfl_ctrl.sv @@
// Controller of the max-flow engine: sequences clear, arc insertion and the
// level search / augmentation phases. Depends on mfl_pkg.
module mfl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  mfl_pkg::mfl_status_type status,
   output mfl_pkg::mfl_cmd_type    cmd
);
   import mfl_pkg::*;

   mfl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_RST:       if (status.sweep_last) state_in = S_IDLE;
         S_IDLE:      if (req_tvalid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (status.act)
               ACT_CLEAR: state_in = S_CLR;
               ACT_ADD:   state_in = status.add_ok ? S_ADD_RD1 : S_DONE;
               ACT_SOLVE: state_in = status.solve_ok ? S_LVL_CLR : S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_CLR:       if (status.sweep_last) state_in = S_DONE;
         S_ADD_RD1:   state_in = S_ADD_WR1;
         S_ADD_WR1:   state_in = S_ADD_RD2;
         S_ADD_RD2:   state_in = S_ADD_WR2;
         S_ADD_WR2:   state_in = S_DONE;
         S_LVL_CLR:   if (status.sweep_last) state_in = S_BFS_SEED;
         S_BFS_SEED:  state_in = S_BFS_POP;
         S_BFS_POP:   state_in = status.q_nonempty ? S_BFS_U : S_SNK_CHK;
         S_BFS_U:     state_in = S_BFS_U2;
         S_BFS_U2:    state_in = S_BFS_ARC;
         S_BFS_ARC:   state_in = status.e_nil ? S_BFS_POP : S_BFS_LAT;
         S_BFS_LAT:   state_in = S_BFS_CHK;
         S_BFS_CHK:   state_in = S_BFS_ARC;
         S_SNK_CHK:   state_in = status.snk_reached ? S_CP_RD : S_DONE;
         S_CP_RD:     state_in = S_CP_WR;
         S_CP_WR:     state_in = status.sweep_last ? S_AUG_START : S_CP_RD;
         S_AUG_START: state_in = S_AUG_TOP;
         S_AUG_TOP: begin
            if (status.push_done)    state_in = S_PHASE_END;
            else if (status.at_sink) state_in = S_MIN_RD;
            else                     state_in = S_CUR_LAT;
         end
         S_CUR_LAT:   state_in = S_SCAN;
         S_SCAN:      state_in = status.e_nil ? S_DEAD : S_SCAN_LAT;
         S_SCAN_LAT:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (!status.arc_ok)        state_in = S_SCAN;
            else if (status.depth_full) state_in = S_PHASE_END;
            else                       state_in = S_AUG_TOP;
         end
         S_DEAD:      state_in = status.depth_zero ? S_PHASE_END : S_BACK;
         S_BACK:      state_in = S_BACK_U;
         S_BACK_U:    state_in = S_AUG_TOP;
         S_MIN_RD:    state_in = status.i_lt_depth ? S_MIN_S : S_UPD_RD;
         S_MIN_S:     state_in = S_MIN_C;
         S_MIN_C:     state_in = S_MIN_RD;
         S_UPD_RD:    state_in = status.i_lt_depth ? S_UPD_S : S_AUG_TOP;
         S_UPD_S:     state_in = S_UPD_A;
         S_UPD_A:     state_in = S_UPD_B;
         S_UPD_B:     state_in = S_UPD_RD;
         S_PHASE_END: state_in = S_LVL_CLR;
         S_DONE:      if (status.out_free) state_in = S_IDLE;
         default:     state_in = S_RST;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.op = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_RST:       cmd.op = OP_CLR;
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_ACCEPT;
         end
         S_DISPATCH:  if (status.act == ACT_ADD && !status.add_ok) cmd.op = OP_ADD_ERR;
         S_CLR:       cmd.op = OP_CLR;
         S_ADD_RD1:   cmd.op = OP_ADD_RD1;
         S_ADD_WR1:   cmd.op = OP_ADD_WR1;
         S_ADD_RD2:   cmd.op = OP_ADD_RD2;
         S_ADD_WR2:   cmd.op = OP_ADD_WR2;
         S_LVL_CLR:   cmd.op = OP_LVL_CLR;
         S_BFS_SEED:  cmd.op = OP_BFS_SEED;
         S_BFS_POP:   cmd.op = status.q_nonempty ? OP_BFS_POP : OP_SNK_RD;
         S_BFS_U:     cmd.op = OP_BFS_U;
         S_BFS_U2:    cmd.op = OP_BFS_U2;
         S_BFS_ARC:   if (!status.e_nil) cmd.op = OP_ARC_RD;
         S_BFS_LAT:   cmd.op = OP_ARC_LAT;
         S_BFS_CHK:   cmd.op = status.bfs_take ? OP_BFS_TAKE : OP_NEXT_ARC;
         S_SNK_CHK:   cmd.op = OP_NONE;
         S_CP_RD:     cmd.op = OP_CP_RD;
         S_CP_WR:     cmd.op = OP_CP_WR;
         S_AUG_START: cmd.op = OP_AUG_START;
         S_AUG_TOP: begin
            if (status.push_done)    cmd.op = OP_NONE;
            else if (status.at_sink) cmd.op = OP_PATH;
            else                     cmd.op = OP_CUR_RD;
         end
         S_CUR_LAT:   cmd.op = OP_CUR_LAT;
         S_SCAN:      cmd.op = status.e_nil ? OP_CUR_NIL : OP_ARC_RD;
         S_SCAN_LAT:  cmd.op = OP_ARC_LAT;
         S_SCAN_CHK: begin
            if (!status.arc_ok)         cmd.op = OP_NEXT_ARC;
            else if (!status.depth_full) cmd.op = OP_ADVANCE;
         end
         S_DEAD:      if (!status.depth_zero) cmd.op = OP_PRUNE;
         S_BACK:      cmd.op = OP_BACK;
         S_BACK_U:    cmd.op = OP_BACK_U;
         S_MIN_RD:    cmd.op = status.i_lt_depth ? OP_STK_RD : OP_UPD_START;
         S_MIN_S:     cmd.op = OP_RES_RD;
         S_MIN_C:     cmd.op = OP_MIN;
         S_UPD_RD:    cmd.op = status.i_lt_depth ? OP_STK_RD : OP_PUSH;
         S_UPD_S:     cmd.op = OP_RES_RD;
         S_UPD_A:     cmd.op = OP_UPD_A;
         S_UPD_B:     cmd.op = OP_UPD_B;
         S_PHASE_END: cmd.op = OP_PHASE_END;
         S_DONE:      if (status.out_free) cmd.op = OP_RESP;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

@@ hdl/max_flow_level_graph_top.sv @@
// Top level of the max-flow engine: controller, datapath and assertions.
// Depends on mfl_pkg, mfl_ctrl, mfl_dp (and mfl_ram through mfl_dp).
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | req_tdata: action, from, to, capacity
//   rsp     | out       | rsp_tvalid/tready   | rsp_tdata: status, total_flow
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One request at a time. Clear sweeps the node table; add arc writes the forward and
// the reverse arc. A solve runs phases of level reset, breadth-first search, pointer
// copy and augmentation, in which the search steps from node to node, scans arcs,
// retreats from dead ends, finds the minimum along each path and updates its arcs.
// After reset a clearing pass over all NODES entries runs before req_tready rises.
// A held result in the output register stalls only the end of the next request.
module max_flow_level_graph_top #(
   parameter int NODES    = mfl_pkg::NODES_DEF,
   parameter int MAX_ARCS = mfl_pkg::MAX_ARCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mfl_pkg::REQ_W-1:0]     req_tdata,  // action, from_node, to_node, capacity
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mfl_pkg::RSP_W-1:0]     rsp_tdata,  // status, total_flow
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfl_pkg::NODE_W-1:0]    csr_data
);
   import mfl_pkg::*;

   mfl_cmd_type    cmd;
   mfl_status_type status;

   assign csr_ready = 1'b1;

   mfl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   mfl_dp #(.NODES(NODES), .MAX_ARCS(MAX_ARCS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_tdata(req_tdata),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

   // a result never carries both an error and a flow
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[36:1] != '0))
      else $error("result carries both error status and flow");

   // loading the result register raises the output valid
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESP) |=> rsp_tvalid)
      else $error("result load did not raise rsp_tvalid");

endmodule

@@ verif/tb_max_flow_level_graph_top.sv @@
// Self-checking testbench for max_flow_level_graph_top: clear, add-arc and solve
// requests checked against an in-bench max-flow predictor. Depends on mfl_pkg.
`timescale 1ns / 100ps

module tb_max_flow_level_graph_top;
   import mfl_pkg::*;

   localparam int unsigned NIL_ARC   = 8192;
   localparam int unsigned NO_LEVEL  = 32'hFFFFF;
   localparam int unsigned LIMIT     = 1000000000;
   localparam int unsigned CAP_TOP   = 32'h3FFFFFFF;

   typedef struct {
      logic        status;
      logic [35:0] flow;
   } rsp_fields_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [NODE_W-1:0]    csr_data;

   max_flow_level_graph_top dut (.*);

   // predictor copy of the graph
   int unsigned pr_head[NIL_ARC];
   int unsigned pr_res[NIL_ARC];
   int unsigned pr_next[NIL_ARC];
   int unsigned pr_first[64];
   int unsigned pr_count;
   int unsigned pr_level[64];
   int unsigned pr_cur[64];
   int unsigned pr_queue[64];
   int unsigned pr_path[64];
   int unsigned pr_source = 0;
   int unsigned pr_sink   = 1;

   logic [REQ_W-1:0] req_backlog[$];
   rsp_fields_type   pending_rsp[$];
   int               gap_left   = 0;
   int               stall_left = 0;
   bit               calm       = 0;
   int               errors     = 0;
   int               n_items    = 0;

   // clock
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   function automatic void clear_graph();
      for (int v = 0; v < 64; v++) pr_first[v] = NIL_ARC;
      pr_count = 0;
   endfunction

   // breadth-first level labelling over arcs with residual capacity
   function automatic bit label_levels(int unsigned s, int unsigned t);
      int unsigned qh, qt, u, e, w;
      qh = 0;
      qt = 0;
      for (int v = 0; v < 64; v++) pr_level[v] = NO_LEVEL;
      pr_level[s] = 0;
      pr_queue[qt] = s;
      qt = qt + 1;
      while (qh < qt) begin
         u = pr_queue[qh];
         qh = qh + 1;
         e = pr_first[u];
         while (e < NIL_ARC) begin
            w = pr_head[e];
            if (pr_level[w] == NO_LEVEL && pr_res[e] > 0 && qt < 64) begin
               pr_level[w] = pr_level[u] + 1;
               pr_queue[qt] = w;
               qt = qt + 1;
            end
            e = pr_next[e];
         end
      end
      return pr_level[t] != NO_LEVEL;
   endfunction

   // level-respecting augmentation, capped per phase
   function automatic int unsigned push_phase(int unsigned s, int unsigned t);
      int unsigned pushed, depth, u, e, b;
      pushed = 0;
      depth = 0;
      u = s;
      for (int v = 0; v < 64; v++) pr_cur[v] = pr_first[v];
      while (pushed < LIMIT) begin
         if (u == t) begin
            b = LIMIT - pushed;
            for (int i = 0; i < depth; i++)
               if (pr_res[pr_path[i]] < b) b = pr_res[pr_path[i]];
            for (int i = 0; i < depth; i++) begin
               pr_res[pr_path[i]] -= b;
               pr_res[pr_path[i] ^ 1] += b;
            end
            pushed += b;
            depth = 0;
            u = s;
            continue;
         end
         e = pr_cur[u];
         while (e < NIL_ARC && !(pr_res[e] > 0 && pr_level[pr_head[e]] == pr_level[u] + 1))
            e = pr_next[e];
         pr_cur[u] = e;
         if (e < NIL_ARC) begin
            if (depth >= 64) break;
            pr_path[depth] = e;
            depth = depth + 1;
            u = pr_head[e];
         end else begin
            if (depth == 0) break;
            pr_level[u] = NO_LEVEL;
            depth = depth - 1;
            u = pr_head[pr_path[depth] ^ 1];
         end
      end
      return pushed;
   endfunction

   function automatic logic [35:0] solve_flow();
      longint unsigned total;
      total = 0;
      if (pr_source == pr_sink) return '0;
      while (label_levels(pr_source, pr_sink)) total += push_phase(pr_source, pr_sink);
      return (total > 64'hFFFFFFFFF) ? 36'hFFFFFFFFF : total[35:0];
   endfunction

   // expected response for one accepted request
   function automatic void predict_response(logic [REQ_W-1:0] w);
      rsp_fields_type r;
      int unsigned fr, to, f;
      mfl_act_type act;
      act = mfl_act_type'(w[1:0]);
      fr = 32'(w[7:2]);
      to = 32'(w[13:8]);
      r.status = 1'b0;
      r.flow = '0;
      if (act == ACT_CLEAR) begin
         clear_graph();
      end else if (act == ACT_ADD) begin
         if (pr_count + 2 > NIL_ARC) begin
            r.status = 1'b1;
         end else begin
            f = pr_count;
            pr_head[f] = to;
            pr_res[f] = 32'(w[43:14]);
            pr_next[f] = pr_first[fr];
            pr_first[fr] = f;
            pr_head[f+1] = fr;
            pr_res[f+1] = 0;
            pr_next[f+1] = pr_first[to];
            pr_first[to] = f + 1;
            pr_count += 2;
         end
      end else if (act == ACT_SOLVE) begin
         r.flow = solve_flow();
      end
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // request driver
   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_response(req_tdata);
         nv = req_tvalid && !req_tready;
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() > 0) begin
               req_tdata <= req_backlog.pop_front();
               nv = 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
            end
         end
         req_tvalid <= nv;
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      rsp_fields_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tdata[0] !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[36:1] !== e.flow) begin
               $display("%0t: total_flow expected %0d actual %0d", $time, e.flow,
                        rsp_tdata[36:1]);
               errors++;
            end
         end
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      rsp_tready <= (stall_left == 0);
   end

   function automatic void send(mfl_act_type act, int unsigned fr, int unsigned to,
                                int unsigned cap);
      req_backlog.insert(req_backlog.size(), {4'b0, cap[29:0], to[5:0], fr[5:0], 2'(act)});
      n_items++;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (!(req_backlog.size() == 0 && !req_tvalid && pending_rsp.size() == 0));
      repeat (80) @(posedge clock);
   endtask

   // register write, only while the engine is idle
   task automatic csr_write(mfl_csr_type idx, int unsigned val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[5:0];
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SOURCE) pr_source = val & 32'h3F;
      else pr_sink = val & 32'h3F;
   endtask

   function automatic int unsigned pick_node();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
   endfunction

   function automatic int unsigned pick_cap();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return LIMIT;
         2: return CAP_TOP;
         3: return $urandom() & CAP_TOP;
         default: return $urandom_range(1, 50);
      endcase
   endfunction

   // stimulus
   initial begin
      int k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SOURCE;
      csr_data   = '0;
      clear_graph();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: small graph, repeated solve, unused action
      send(ACT_CLEAR, 0, 0, 0);
      send(ACT_ADD, 0, 1, 5);
      send(ACT_ADD, 0, 2, CAP_TOP);
      send(ACT_ADD, 2, 1, LIMIT);
      send(ACT_ADD, 63, 0, 0);
      send(ACT_ADD, 2, 63, CAP_TOP);
      send(ACT_SOLVE, 0, 0, 0);
      send(ACT_SOLVE, 0, 0, 0);
      send(mfl_act_type'(2'd3), 63, 63, CAP_TOP);
      // degenerate solve with source equal to sink
      csr_write(CSR_SINK, 0);
      send(ACT_SOLVE, 0, 0, 0);
      // extreme node indexes
      csr_write(CSR_SOURCE, 63);
      send(ACT_ADD, 63, 2, 7);
      send(ACT_SOLVE, 0, 0, 0);
      csr_write(CSR_SOURCE, 0);
      csr_write(CSR_SINK, 1);

      // saturating total flow
      send(ACT_CLEAR, 0, 0, 0);
      for (int i = 0; i < 70; i++) send(ACT_ADD, 0, 1, CAP_TOP);
      send(ACT_SOLVE, 0, 0, 0);
      send(ACT_CLEAR, 0, 0, 0);

      // random graphs, each under its own source and sink
      while (n_items < 800) begin
         if (n_items > 700) calm = 1;
         k = $urandom_range(0, 9);
         csr_write(CSR_SOURCE, (k == 0) ? 63 : $urandom_range(0, 7));
         csr_write(CSR_SINK, (k == 1) ? 0 : (k == 2) ? pr_source : $urandom_range(0, 7));
         send(ACT_CLEAR, 0, 0, 0);
         for (int r = 0; r < 1 + $urandom_range(0, 2); r++) begin
            for (int a = 0; a < $urandom_range(3, 25); a++) begin
               if ($urandom_range(0, 19) == 0) send(mfl_act_type'(2'd3), pick_node(),
                                                    pick_node(), $urandom());
               else send(ACT_ADD, pick_node(), pick_node(), pick_cap());
            end
            send(ACT_SOLVE, pick_node(), pick_node(), $urandom());
         end
      end

      wait_idle();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // run limit
   initial begin
      #100ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
